// ----- hw/rtl/tdes_pkg.sv -----
// tdes_pkg: DES tables, permutation and round functions, register indexes
// and the stage record shared by the round cells and the top level.
// No dependencies.
package tdes_pkg;

   typedef enum logic [2:0] {
      REG_KEY_FIRST    = 3'd0,
      REG_KEY_SECOND   = 3'd1,
      REG_KEY_THIRD    = 3'd2,
      REG_KEY_MODE     = 3'd3,
      REG_DECRYPT_MODE = 3'd4,
      REG_INIT_VECTOR  = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_SINGLE   = 2'd0,
      MODE_TWO_KEY  = 2'd1,
      MODE_THREE_KEY = 2'd2
   } key_mode_type;

   localparam int NUM_ROUNDS = 16;
   localparam int NUM_CELLS  = 48;
   localparam int ADDR_WIDTH = 6;

   typedef struct packed {
      logic        valid;
      logic        last;
      logic [63:0] mask;
      logic [31:0] l;
      logic [31:0] r;
   } stage_type;

   localparam logic [6:0] IP_TBL [64] = '{
      58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
   localparam logic [6:0] FP_TBL [64] = '{
      40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
   localparam logic [6:0] E_TBL [48] = '{
      32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
      16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
   localparam logic [6:0] P_TBL [32] = '{
      16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
   localparam logic [6:0] PC1_TBL [56] = '{
      57,49,41,33,25,17,9,1,58,50,42,34,26,18,
      10,2,59,51,43,35,27,19,11,3,60,52,44,36,
      63,55,47,39,31,23,15,7,62,54,46,38,30,22,
      14,6,61,53,45,37,29,21,13,5,28,20,12,4};
   localparam logic [6:0] PC2_TBL [48] = '{
      14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
      41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
   // cumulative left rotation of C and D after each round
   localparam logic [4:0] ROT_SUM [16] = '{
      1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};
   localparam logic [3:0] SBOX [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,5,3,0,6,11}};

   function automatic logic [63:0] des_ip(input logic [63:0] x);
      logic [63:0] o;
      for (int i = 0; i < 64; i++) o[63-i] = x[64-IP_TBL[i]];
      return o;
   endfunction

   function automatic logic [63:0] des_fp(input logic [63:0] x);
      logic [63:0] o;
      for (int i = 0; i < 64; i++) o[63-i] = x[64-FP_TBL[i]];
      return o;
   endfunction

   function automatic logic [47:0] des_subkey(input logic [63:0] key, input logic [3:0] idx);
      logic [55:0] cd;
      logic [55:0] cc;
      logic [55:0] dd;
      logic [55:0] rot;
      logic [47:0] o;
      for (int i = 0; i < 56; i++) cd[55-i] = key[64-PC1_TBL[i]];
      cc = {cd[55:28], cd[55:28]} << ROT_SUM[idx];
      dd = {cd[27:0], cd[27:0]} << ROT_SUM[idx];
      rot = {cc[55:28], dd[55:28]};
      for (int i = 0; i < 48; i++) o[47-i] = rot[56-PC2_TBL[i]];
      return o;
   endfunction

   function automatic logic [31:0] des_feistel(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] e;
      logic [5:0]  six;
      logic [31:0] s;
      logic [31:0] o;
      for (int i = 0; i < 48; i++) e[47-i] = r[32-E_TBL[i]];
      e = e ^ k;
      for (int i = 0; i < 8; i++) begin
         six = e[47-6*i -: 6];
         s[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) o[31-i] = s[32-P_TBL[i]];
      return o;
   endfunction

endpackage

// ----- hw/rtl/tdes_if.sv -----
// tdes_if: request and response channel interfaces for the cipher.
// No dependencies.
interface tdes_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_in;
   logic        first_block;
   logic        last_block;
   modport source (output valid, output block_in, output first_block, output last_block,
                   input ready);
   modport sink (input valid, input block_in, input first_block, input last_block,
                 output ready);
endinterface

interface tdes_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_out;
   logic        end_of_message;
   modport source (output valid, output block_out, output end_of_message, input ready);
   modport sink (input valid, input block_out, input end_of_message, output ready);
endinterface

// ----- hw/rtl/tdes_round_cell.sv -----
// tdes_round_cell: one DES round with its pipeline register.
// Depends on tdes_pkg.
module tdes_round_cell import tdes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        no_swap,
   input  logic [47:0] subkey,
   input  stage_type   prev,
   output stage_type   cur
);
   stage_type   cur_ff;
   stage_type   cur_in;
   logic [31:0] mix;

   always_comb begin
      mix          = prev.l ^ des_feistel(prev.r, subkey);
      cur_in       = prev;
      cur_in.l     = no_swap ? mix : prev.r;
      cur_in.r     = no_swap ? prev.r : mix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.valid <= 1'b0;
      end else if (enable) begin
         cur_ff.valid <= cur_in.valid;
      end
      if (enable) begin
         cur_ff.last <= cur_in.last;
         cur_ff.mask <= cur_in.mask;
         cur_ff.l    <= cur_in.l;
         cur_ff.r    <= cur_in.r;
      end
   end

   assign cur = cur_ff;
endmodule

// ----- hw/rtl/tdes_cbc_cipher.sv -----
// tdes_cbc_cipher: CBC-mode DES / triple-DES EDE engine, top level.
// Depends on tdes_pkg, tdes_if and tdes_round_cell.
//
// Usage:
//  - req_if carries one 64-bit block per beat with first_block (chain from
//    init_vector) and last_block (copied to end_of_message on rsp_if).
//  - rsp_if returns one result beat per request beat, in order.
//  - csr_* is an APB write/read port; registers sit at byte address 8*index.
//    Write registers only while the engine is idle.
//  - Each block passes an entry register, a row of 48 round cells (three
//    DES passes; single DES runs K1 three times) and an output register
//    on the way from request beat to response valid.
//  - Decrypt: one block per cycle if not stalled; chain is the input block.
//  - Encrypt: the next block needs the previous ciphertext, so a block is
//    accepted only once the entry register and the cell row are empty.
//  - A stalled response freezes the whole row; nothing is dropped.
//  - Reset clears the CSR registers, the chain and all valid flags.
module tdes_cbc_cipher import tdes_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tdes_req_if.sink              req_if,
   tdes_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [63:0]           csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready
);
   logic [63:0] key_first_ff, key_second_ff, key_third_ff, init_vector_ff;
   logic [1:0]  key_mode_ff;
   logic        decrypt_mode_ff;
   logic [63:0] chain_ff;
   logic        rsp_valid_ff;
   logic [63:0] block_out_ff;
   logic        eom_ff;
   stage_type   entry_ff;
   stage_type   stages [NUM_CELLS+1];
   logic [NUM_CELLS:0] busy;
   logic        enable;
   logic        accept;
   logic        csr_write;
   reg_index_type csr_index;
   logic [63:0] chain_sel;
   logic [63:0] x_in;
   logic [63:0] k2_eff, k3_eff;
   logic [63:0] result;
   stage_type   tail;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[ADDR_WIDTH-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_first_ff    <= '0;
         key_second_ff   <= '0;
         key_third_ff    <= '0;
         key_mode_ff     <= '0;
         decrypt_mode_ff <= 1'b0;
         init_vector_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_KEY_FIRST:    key_first_ff    <= csr_pwdata;
            REG_KEY_SECOND:   key_second_ff   <= csr_pwdata;
            REG_KEY_THIRD:    key_third_ff    <= csr_pwdata;
            REG_KEY_MODE:     key_mode_ff     <= csr_pwdata[1:0];
            REG_DECRYPT_MODE: decrypt_mode_ff <= csr_pwdata[0];
            REG_INIT_VECTOR:  init_vector_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_KEY_FIRST:    csr_prdata = key_first_ff;
         REG_KEY_SECOND:   csr_prdata = key_second_ff;
         REG_KEY_THIRD:    csr_prdata = key_third_ff;
         REG_KEY_MODE:     csr_prdata = {62'd0, key_mode_ff};
         REG_DECRYPT_MODE: csr_prdata = {63'd0, decrypt_mode_ff};
         REG_INIT_VECTOR:  csr_prdata = init_vector_ff;
         default:          csr_prdata = '0;
      endcase
   end

   // single DES runs E/D/E with K1 everywhere
   assign k2_eff = (key_mode_ff == MODE_SINGLE) ? key_first_ff : key_second_ff;
   assign k3_eff = (key_mode_ff == MODE_SINGLE || key_mode_ff == MODE_TWO_KEY) ?
                   key_first_ff : key_third_ff;

   assign enable = !rsp_valid_ff || rsp_if.ready;
   assign tail   = stages[NUM_CELLS];

   always_comb begin
      for (int i = 0; i <= NUM_CELLS; i++) busy[i] = stages[i].valid;
   end

   assign req_if.ready = enable && (decrypt_mode_ff || !(|busy));
   assign accept       = req_if.valid && req_if.ready;
   assign chain_sel    = req_if.first_block ? init_vector_ff : chain_ff;
   assign x_in         = decrypt_mode_ff ? req_if.block_in : (req_if.block_in ^ chain_sel);
   assign result       = des_fp({tail.l, tail.r}) ^ tail.mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (enable) begin
         entry_ff.valid <= accept;
      end
      if (accept) begin
         entry_ff.last <= req_if.last_block;
         entry_ff.mask <= decrypt_mode_ff ? chain_sel : 64'd0;
         {entry_ff.l, entry_ff.r} <= des_ip(x_in);
      end
   end

   assign stages[0] = entry_ff;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      localparam int Pass = g / NUM_ROUNDS;
      localparam int Rnd  = g % NUM_ROUNDS;
      logic        dir;
      logic [63:0] pass_key;
      logic [3:0]  kidx;
      logic [47:0] subkey;

      always_comb begin
         dir = decrypt_mode_ff ^ (Pass == 1);
         if (Pass == 1) begin
            pass_key = k2_eff;
         end else if ((Pass == 0) != decrypt_mode_ff) begin
            pass_key = key_first_ff;
         end else begin
            pass_key = k3_eff;
         end
         kidx   = dir ? 4'(NUM_ROUNDS - 1 - Rnd) : 4'(Rnd);
         subkey = des_subkey(pass_key, kidx);
      end

      tdes_round_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .no_swap (Rnd == NUM_ROUNDS - 1),
         .subkey  (subkey),
         .prev    (stages[g]),
         .cur     (stages[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         if (enable) begin
            rsp_valid_ff <= tail.valid;
         end
         if (accept && decrypt_mode_ff) begin
            chain_ff <= req_if.block_in;
         end else if (enable && tail.valid && !decrypt_mode_ff) begin
            chain_ff <= result;
         end
      end
      if (enable && tail.valid) begin
         block_out_ff <= result;
         eom_ff       <= tail.last;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.block_out      = block_out_ff;
   assign rsp_if.end_of_message = eom_ff;
endmodule

// ----- hw/rtl/tdes_checker.sv -----
// tdes_checker: port-level assertions for tdes_cbc_cipher, bound to the top.
// Depends on tdes_pkg and tdes_cbc_cipher.
module tdes_checker import tdes_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_block_out,
   input logic        csr_pready,
   input logic        req_ready
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_block_out))
      else $error("response payload changed while stalled");

   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while the response is stalled");

   assert property (@(posedge clock) csr_pready)
      else $error("csr wait state");
endmodule

bind tdes_cbc_cipher tdes_checker u_tdes_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_block_out (rsp_if.block_out),
   .csr_pready    (csr_pready),
   .req_ready     (req_if.ready)
);

// ----- tb/tdes_cbc_cipher_tb.sv -----
`timescale 1ns / 100ps
// tdes_cbc_cipher_tb: self-checking bench for the CBC DES / triple-DES engine.
// Depends on tdes_pkg, tdes_if and tdes_cbc_cipher; a built-in cipher
// predictor checks every response beat against the expected block in order.
module tdes_cbc_cipher_tb;
   import tdes_pkg::*;

   localparam int LIMIT_CYCLES = 2000000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [63:0] block;
      logic        eom;
   } cipher_beat_type;

   class cbc_scoreboard;
      logic [63:0] key1, key2, key3, ivec, chain;
      logic [1:0]  kmode;
      logic        decrypt;
      cipher_beat_type pending_q[$];
      int errors;

      function new();
         key1 = '0; key2 = '0; key3 = '0; ivec = '0; chain = '0;
         kmode = MODE_SINGLE; decrypt = 1'b0; errors = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [63:0] val);
         case (idx)
            REG_KEY_FIRST:    key1 = val;
            REG_KEY_SECOND:   key2 = val;
            REG_KEY_THIRD:    key3 = val;
            REG_KEY_MODE:     kmode = val[1:0];
            REG_DECRYPT_MODE: decrypt = val[0];
            REG_INIT_VECTOR:  ivec = val;
            default: ;
         endcase
      endfunction

      function logic [63:0] des_pass(logic [63:0] key, logic [63:0] x, logic inv);
         logic [55:0] cd;
         logic [27:0] c, d;
         logic [47:0] sk [16];
         logic [63:0] v;
         logic [31:0] l, r, t, s, f;
         logic [47:0] e;
         logic [5:0]  six;
         for (int i = 0; i < 56; i++) cd[55-i] = key[64-PC1_TBL[i]];
         c = cd[55:28];
         d = cd[27:0];
         for (int i = 0; i < 16; i++) begin
            int n;
            n = (i == 0 || i == 1 || i == 8 || i == 15) ? 1 : 2;
            for (int j = 0; j < n; j++) begin
               c = {c[26:0], c[27]};
               d = {d[26:0], d[27]};
            end
            cd = {c, d};
            for (int j = 0; j < 48; j++) sk[i][47-j] = cd[56-PC2_TBL[j]];
         end
         for (int i = 0; i < 64; i++) v[63-i] = x[64-IP_TBL[i]];
         l = v[63:32];
         r = v[31:0];
         for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 48; j++) e[47-j] = r[32-E_TBL[j]];
            e = e ^ sk[inv ? 15 - i : i];
            for (int j = 0; j < 8; j++) begin
               six = e[47-6*j -: 6];
               s[31-4*j -: 4] = SBOX[j][{six[5], six[0], six[4:1]}];
            end
            for (int j = 0; j < 32; j++) f[31-j] = s[32-P_TBL[j]];
            t = r;
            r = l ^ f;
            l = t;
         end
         v = {r, l};
         for (int i = 0; i < 64; i++) des_pass[63-i] = v[64-FP_TBL[i]];
      endfunction

      function logic [63:0] ede(logic [63:0] x, logic inv);
         logic [63:0] k3;
         k3 = (kmode == MODE_TWO_KEY) ? key1 : key3;
         if (kmode == MODE_SINGLE) return des_pass(key1, x, inv);
         if (!inv) return des_pass(k3, des_pass(key2, des_pass(key1, x, 0), 1), 0);
         return des_pass(key1, des_pass(key2, des_pass(k3, x, 1), 0), 1);
      endfunction

      function void note_block(logic [63:0] blk, logic first, logic last);
         cipher_beat_type b;
         logic [63:0] link;
         link = first ? ivec : chain;
         if (decrypt) begin
            b.block = ede(blk, 1) ^ link;
            chain = blk;
         end else begin
            b.block = ede(blk ^ link, 0);
            chain = b.block;
         end
         b.eom = last;
         pending_q.push_back(b);
      endfunction

      function void check_block(logic [63:0] blk, logic eom);
         cipher_beat_type b;
         if (pending_q.size() == 0) begin
            $error("unexpected response beat block_out=%h", blk);
            errors++;
            return;
         end
         b = pending_q.pop_front();
         if (blk !== b.block) begin
            $error("block_out expected %h actual %h", b.block, blk);
            errors++;
         end
         if (eom !== b.eom) begin
            $error("end_of_message expected %b actual %b", b.eom, eom);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;
   logic calm = 1'b0;
   int cycles = 0;

   tdes_req_if req ();
   tdes_rsp_if rsp ();
   cbc_scoreboard sb = new();

   initial begin
      req.valid = 1'b0;
      req.block_in = '0;
      req.first_block = 1'b0;
      req.last_block = 1'b0;
      rsp.ready = 1'b0;
   end

   tdes_cbc_cipher dut (
      .clock(clock), .reset(reset), .req_if(req.sink), .rsp_if(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("tdes_cbc_cipher_tb: errors");
         $finish;
      end
   end

   // response sink: check accepted beats, random backpressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) sb.check_block(rsp.block_out, rsp.end_of_message);
         rsp.ready <= calm || ($urandom_range(0, 99) >= 24);
      end
   end

   task automatic write_reg(reg_index_type idx, logic [63:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_WIDTH'(8 * int'(idx));
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_block(logic [63:0] blk, logic first, logic last);
      while (!calm && $urandom_range(0, 99) < 24) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.block_in <= blk;
      req.first_block <= first;
      req.last_block <= last;
      do @(posedge clock); while (!req.ready);
      sb.note_block(blk, first, last);
   endtask

   task automatic settle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic setup_phase(logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
                              logic [1:0] km, logic dm, logic [63:0] iv);
      write_reg(REG_KEY_FIRST, k1);
      write_reg(REG_KEY_SECOND, k2);
      write_reg(REG_KEY_THIRD, k3);
      write_reg(REG_KEY_MODE, {62'd0, km});
      write_reg(REG_DECRYPT_MODE, {63'd0, dm});
      write_reg(REG_INIT_VECTOR, iv);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      int left, len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state: zero keys, zero chain, encrypt
      send_block('0, 1'b0, 1'b0);
      send_block('1, 1'b0, 1'b1);
      send_block(64'h0123456789abcdef, 1'b1, 1'b0);
      send_block(64'h0123456789abcdef, 1'b0, 1'b1);
      settle();
      setup_phase('1, '1, '1, MODE_SINGLE, 1'b1, '1);
      send_block('1, 1'b1, 1'b0);
      send_block('0, 1'b0, 1'b1);
      send_block(64'h5555aaaa5555aaaa, 1'b0, 1'b0);
      settle();
      setup_phase(64'h0123456789abcdef, 64'h23456789abcdef01, 64'h456789abcdef0123,
                  MODE_TWO_KEY, 1'b0, 64'h1234567890abcdef);
      send_block(64'h4e6f772069732074, 1'b1, 1'b0);
      send_block(64'h68652074696d6520, 1'b0, 1'b1);
      send_block(64'h666f7220616c6c20, 1'b1, 1'b1);
      settle();
      write_reg(REG_KEY_MODE, 64'd3);
      send_block(64'h8000000000000001, 1'b1, 1'b0);
      send_block(64'h7ffffffffffffffe, 1'b0, 1'b1);
      settle();
      setup_phase(64'hfedcba9876543210, 64'h0f1e2d3c4b5a6978, 64'h8899aabbccddeeff,
                  MODE_THREE_KEY, 1'b1, '0);
      send_block(64'haaaaaaaaaaaaaaaa, 1'b1, 1'b0);
      send_block(64'h5555555555555555, 1'b0, 1'b0);
      send_block(64'h0000000000000001, 1'b0, 1'b1);
      settle();

      for (int ph = 0; ph < 12; ph++) begin
         setup_phase(rand64(), rand64(), rand64(), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)),
                     (ph == 3) ? '0 : (ph == 4) ? '1 : rand64());
         calm = (ph == 5 || ph == 6);
         left = 90;
         while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
               send_block(rand64(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               left--;
            end else begin
               len = $urandom_range(1, 8);
               for (int i = 0; i < len; i++)
                  send_block(rand64(), i == 0, i == len - 1);
               left -= len;
            end
         end
         settle();
      end
      calm = 1'b0;

      if (sb.errors == 0) begin
         $display("tdes_cbc_cipher_tb: clean");
      end else begin
         $display("tdes_cbc_cipher_tb: errors");
      end
      $finish;
   end
endmodule
